[src/csml_pkg.sv]
// Shared types, codes and byte helpers for the caseless string map.
// No dependencies.
package csml_pkg;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_LOOKUP = 2'd1;
  localparam logic [1:0] KIND_CLEAR  = 2'd2;

  localparam logic [2:0] STAT_DONE  = 3'd0;
  localparam logic [2:0] STAT_FOUND = 3'd1;
  localparam logic [2:0] STAT_MISS  = 3'd2;
  localparam logic [2:0] STAT_FULL  = 3'd3;
  localparam logic [2:0] STAT_LONG  = 3'd4;

  localparam int          LEN_W     = 9;
  localparam logic [31:0] HASH_SEED = 32'd5381;
  localparam logic [7:0]  COLON     = 8'h3A;
  localparam logic [7:0]  UPPER_A   = 8'h41;
  localparam logic [7:0]  ALPHA_SPAN = 8'd25;
  localparam logic [7:0]  CASE_OFF  = 8'd32;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] value_byte;
    logic       value_valid;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic             cmode;
    logic             colon;
    logic             over;
    logic             bank;
    logic [LEN_W-1:0] len;
    logic [LEN_W-1:0] kpos;
    logic [31:0]      hash;
  } job_t;

  function automatic logic [7:0] fold(input logic [7:0] b);
    logic [7:0] c;
    c = b - UPPER_A;
    if (c <= ALPHA_SPAN) c = c + CASE_OFF;
    return c;
  endfunction

  function automatic logic [31:0] hash_step(input logic [31:0] h, input logic [7:0] b);
    return ((h << 5) + h) ^ {24'd0, fold(b)};
  endfunction

endpackage

[src/csml_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module csml_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

[src/csml_fifo.sv]
// Small register FIFO used for the job queue and the result queue.
// No dependencies.
module csml_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] data_o
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, wp_d, rp_q, rp_d;
  logic [AW:0]      cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = cnt_q == (AW + 1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_push) wp_d = (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
    if (do_pop) rp_d = (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
    if (do_push && !do_pop) cnt_d = cnt_q + 1'b1;
    else if (do_pop && !do_push) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end
endmodule

[src/csml_mod.sv]
// Bucket remainder unit: 32-bit hash modulo BUCKETS by reciprocal multiply.
// The hash is registered on start, then the product, quotient and remainder. No dependencies.
module csml_mod #(
  parameter int BUCKETS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] hash_i,
  output logic        busy_o,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] rem_o
);
  localparam int BKW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int SH  = 32 + $clog2(BUCKETS);
  localparam logic [63:0] MAGIC =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

  logic [1:0]     cnt_q;
  logic [31:0]    h_q, q_q;
  logic [64:0]    p_q;
  logic [31:0]    r_full;
  logic [BKW-1:0] r_q;

  // quotient = floor(h * MAGIC / 2^SH), exact for every 32-bit h
  assign r_full = h_q - q_q * 32'(BUCKETS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= 2'd3;
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) h_q <= hash_i;
    p_q <= 65'(h_q) * 65'(MAGIC[32:0]);
    q_q <= 32'(p_q >> SH);
    r_q <= r_full[BKW-1:0];
  end

  assign busy_o = cnt_q != '0;
  assign rem_o  = r_q;
endmodule

[src/csml_front.sv]
// Front end: assembles entry and key bytes, hashes them and queues jobs.
// Depends on csml_pkg.
module csml_front
  import csml_pkg::*;
#(
  parameter int KEY_MAX   = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  in_item_t item_i,
  output logic     full_o,
  input  logic     cfg_we_i,
  input  logic     cfg_wdata_i,
  input  logic     hold_i,
  input  logic     job_full_i,
  output logic     job_push_o,
  output job_t     job_o,
  output logic     pwe_o,
  output logic [$clog2(2 * (KEY_MAX + VALUE_MAX + 1))-1:0] pwaddr_o,
  output logic [7:0] pwdata_o
);
  localparam int PEND = KEY_MAX + VALUE_MAX + 1;
  localparam int PAW  = $clog2(2 * PEND);
  localparam int LW   = $clog2(PEND + 1);

  logic          cmode_q, active_q, over_q, colon_q, bank_q;
  logic [1:0]    kind_q;
  logic [LW-1:0] len_q, kpos_q;
  logic [31:0]   hall_q, hkey_q;

  logic          accept, is_data, drop, room;
  logic          colon0, over0, colon1, over1;
  logic [LW-1:0] len0, kpos0, len1, kpos1;
  logic [31:0]   hall0, hkey0, hall1, hkey1;
  logic          is_colon;

  assign full_o   = job_full_i || hold_i;
  assign accept   = push_i && !full_o;
  assign is_data  = (item_i.kind == KIND_INSERT) || (item_i.kind == KIND_LOOKUP);
  assign drop     = active_q && (kind_q != item_i.kind);
  assign is_colon = item_i.data_byte == COLON;

  always_comb begin
    len0   = drop ? '0 : len_q;
    kpos0  = drop ? '0 : kpos_q;
    colon0 = drop ? 1'b0 : colon_q;
    over0  = drop ? 1'b0 : over_q;
    hall0  = drop ? HASH_SEED : hall_q;
    hkey0  = drop ? HASH_SEED : hkey_q;
    room   = len0 < LW'(PEND);
    colon1 = colon0 || is_colon;
    over1  = over0 || !room;
    len1   = room ? len0 + 1'b1 : len0;
    hall1  = room ? hash_step(hall0, item_i.data_byte) : hall0;
    hkey1  = (room && !colon1) ? hash_step(hkey0, item_i.data_byte) : hkey0;
    kpos1  = (room && !colon0 && is_colon) ? len0 : kpos0;
  end

  assign pwe_o    = accept && is_data && room;
  assign pwaddr_o = bank_q ? PAW'(PEND) + PAW'(len0) : PAW'(len0);
  assign pwdata_o = item_i.data_byte;

  assign job_push_o = accept && ((item_i.kind == KIND_CLEAR) || (is_data && item_i.last));

  always_comb begin
    job_o.kind  = item_i.kind;
    job_o.cmode = cmode_q;
    job_o.colon = colon1;
    job_o.over  = over1;
    job_o.bank  = bank_q;
    job_o.len   = LEN_W'(len1);
    job_o.kpos  = LEN_W'(kpos1);
    job_o.hash  = ((item_i.kind == KIND_INSERT) && cmode_q) ? hkey1 : hall1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmode_q  <= 1'b1;
      active_q <= 1'b0;
      kind_q   <= KIND_INSERT;
      len_q    <= '0;
      kpos_q   <= '0;
      over_q   <= 1'b0;
      colon_q  <= 1'b0;
      hall_q   <= HASH_SEED;
      hkey_q   <= HASH_SEED;
      bank_q   <= 1'b0;
    end else begin
      if (cfg_we_i) cmode_q <= cfg_wdata_i;
      if (accept && (item_i.kind == KIND_CLEAR || (is_data && item_i.last))) begin
        active_q <= 1'b0;
        kind_q   <= KIND_INSERT;
        len_q    <= '0;
        kpos_q   <= '0;
        over_q   <= 1'b0;
        colon_q  <= 1'b0;
        hall_q   <= HASH_SEED;
        hkey_q   <= HASH_SEED;
        bank_q   <= !bank_q;
      end else if (accept && is_data) begin
        active_q <= 1'b1;
        kind_q   <= item_i.kind;
        len_q    <= len1;
        kpos_q   <= kpos1;
        over_q   <= over1;
        colon_q  <= colon1;
        hall_q   <= hall1;
        hkey_q   <= hkey1;
      end
    end
  end
endmodule

[src/csml_back.sv]
// Back end: runs insert, lookup and clear jobs against the table memories.
// Depends on csml_pkg, csml_ram and csml_mod.
module csml_back
  import csml_pkg::*;
#(
  parameter int ENTRIES   = 256,
  parameter int BUCKETS   = 64,
  parameter int KEY_MAX   = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      job_empty_i,
  output logic      job_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output out_item_t out_o,
  output logic      init_o,
  output logic [$clog2(2 * (KEY_MAX + VALUE_MAX + 1))-1:0] praddr_o,
  input  logic [7:0] prdata_i
);
  localparam int SLOT = KEY_MAX + VALUE_MAX;
  localparam int PEND = SLOT + 1;
  localparam int IW   = $clog2(ENTRIES);
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int BKW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int TAW  = $clog2(ENTRIES * SLOT);
  localparam int PAW  = $clog2(2 * PEND);
  localparam int KLW  = $clog2(KEY_MAX + 1);
  localparam int VLW  = $clog2(VALUE_MAX + 1);
  localparam int MW   = 1 + IW + VLW + KLW + 32;
  localparam int BW   = 1 + IW;

  typedef enum logic [14:0] {
    S_INIT = 15'h0001,
    S_IDLE = 15'h0002,
    S_DEC  = 15'h0004,
    S_MOD  = 15'h0008,
    S_BRD  = 15'h0010,
    S_BCHK = 15'h0020,
    S_MRD  = 15'h0040,
    S_MCHK = 15'h0080,
    S_CRD  = 15'h0100,
    S_CCMP = 15'h0200,
    S_VRD  = 15'h0400,
    S_VOUT = 15'h0800,
    S_CPRD = 15'h1000,
    S_CPWR = 15'h2000,
    S_CLR  = 15'h4000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [BKW-1:0]   sweep_q, sweep_d;
  logic             inc_q, inc_d;
  logic             res_pend_q, res_pend_d;
  logic [2:0]       res_q, res_d;
  logic [IW-1:0]    pos_q, pos_d, next_q, next_d;
  logic [TAW-1:0]   base_q, base_d, dst_q, dst_d;
  logic [LEN_W-1:0] j_q, j_d;
  logic [KLW-1:0]   kl_q, kl_d;
  logic [VLW-1:0]   vl_q, vl_d;
  logic             end_q, end_d;

  logic             mod_start, mod_busy;
  logic [BKW-1:0]   mod_rem;

  logic             bk_we;
  logic [BKW-1:0]   bk_waddr, bk_raddr;
  logic [BW-1:0]    bk_wdata, bk_rdata;
  logic             mt_we;
  logic [IW-1:0]    mt_waddr, mt_raddr;
  logic [MW-1:0]    mt_wdata, mt_rdata;
  logic             tx_we;
  logic [TAW-1:0]   tx_waddr, tx_raddr;
  logic [7:0]       tx_rdata;

  logic [LEN_W-1:0] klen, vlen;
  logic [PAW-1:0]   pbase;
  logic             m_end;
  logic [IW-1:0]    m_next;
  logic [VLW-1:0]   m_vl;
  logic [KLW-1:0]   m_kl;
  logic [31:0]      m_hash;

  csml_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk_i, .rst_ni, .start_i(mod_start), .hash_i(job_i.hash),
    .busy_o(mod_busy), .rem_o(mod_rem)
  );

  csml_ram #(.WIDTH(BW), .DEPTH(BUCKETS)) u_bucket (
    .clk_i, .we_i(bk_we), .waddr_i(bk_waddr), .wdata_i(bk_wdata),
    .raddr_i(bk_raddr), .rdata_o(bk_rdata)
  );

  csml_ram #(.WIDTH(MW), .DEPTH(ENTRIES)) u_meta (
    .clk_i, .we_i(mt_we), .waddr_i(mt_waddr), .wdata_i(mt_wdata),
    .raddr_i(mt_raddr), .rdata_o(mt_rdata)
  );

  csml_ram #(.WIDTH(8), .DEPTH(ENTRIES * SLOT)) u_text (
    .clk_i, .we_i(tx_we), .waddr_i(tx_waddr), .wdata_i(prdata_i),
    .raddr_i(tx_raddr), .rdata_o(tx_rdata)
  );

  assign {m_end, m_next, m_vl, m_kl, m_hash} = mt_rdata;
  assign pbase    = job_i.bank ? PAW'(PEND) : '0;
  assign praddr_o = pbase + PAW'(j_q);
  assign klen     = job_i.cmode ? job_i.kpos : job_i.len;
  assign vlen     = job_i.cmode ? job_i.len - job_i.kpos - 1'b1 : '0;
  assign init_o   = state_q == S_INIT;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    sweep_d    = sweep_q;
    inc_d      = inc_q;
    res_pend_d = res_pend_q;
    res_d      = res_q;
    pos_d      = pos_q;
    next_d     = next_q;
    base_d     = base_q;
    dst_d      = dst_q;
    j_d        = j_q;
    kl_d       = kl_q;
    vl_d       = vl_q;
    end_d      = end_q;
    mod_start  = 1'b0;
    bk_we      = 1'b0;
    bk_waddr   = mod_rem;
    bk_wdata   = {1'b1, cnt_q[IW-1:0]};
    bk_raddr   = mod_rem;
    mt_we      = 1'b0;
    mt_waddr   = cnt_q[IW-1:0];
    mt_wdata   = {!bk_rdata[BW-1], bk_rdata[IW-1:0], vl_q, kl_q, job_i.hash};
    mt_raddr   = pos_q;
    tx_we      = 1'b0;
    tx_waddr   = dst_q;
    tx_raddr   = base_q + TAW'(j_q);
    job_pop_o  = 1'b0;
    out_push_o = 1'b0;
    out_o      = '{status: res_q, value_byte: 8'd0, value_valid: 1'b0, run_end: 1'b1};

    if (res_pend_q) begin
      if (!out_full_i) begin
        out_push_o = 1'b1;
        job_pop_o  = 1'b1;
        res_pend_d = 1'b0;
        if (inc_q) cnt_d = cnt_q + 1'b1;
        inc_d   = 1'b0;
        state_d = S_IDLE;
      end
    end else begin
      case (state_q)
        S_INIT, S_CLR: begin
          bk_we    = 1'b1;
          bk_waddr = sweep_q;
          bk_wdata = '0;
          sweep_d  = sweep_q + 1'b1;
          if (sweep_q == BKW'(BUCKETS - 1)) begin
            sweep_d = '0;
            if (state_q == S_INIT) begin
              state_d = S_IDLE;
            end else begin
              res_d      = STAT_DONE;
              res_pend_d = 1'b1;
            end
          end
        end
        S_IDLE: begin
          if (!job_empty_i) state_d = S_DEC;
        end
        S_DEC: begin
          j_d = '0;
          case (job_i.kind)
            KIND_CLEAR: begin
              cnt_d   = '0;
              sweep_d = '0;
              state_d = S_CLR;
            end
            KIND_INSERT: begin
              if (job_i.cmode && !job_i.colon) begin
                res_d = STAT_DONE;
                res_pend_d = 1'b1;
              end else if (job_i.over || klen > LEN_W'(KEY_MAX) ||
                           vlen > LEN_W'(VALUE_MAX)) begin
                res_d = STAT_LONG;
                res_pend_d = 1'b1;
              end else if (cnt_q >= CW'(ENTRIES)) begin
                res_d = STAT_FULL;
                res_pend_d = 1'b1;
              end else begin
                kl_d      = KLW'(klen);
                vl_d      = VLW'(vlen);
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            KIND_LOOKUP: begin
              if (job_i.over || job_i.len > LEN_W'(KEY_MAX)) begin
                res_d = STAT_LONG;
                res_pend_d = 1'b1;
              end else begin
                kl_d      = KLW'(job_i.len);
                mod_start = 1'b1;
                state_d   = S_MOD;
              end
            end
            default: begin
              res_d = STAT_DONE;
              res_pend_d = 1'b1;
            end
          endcase
        end
        S_MOD: begin
          if (!mod_busy) state_d = S_BRD;
        end
        S_BRD: begin
          state_d = S_BCHK;
        end
        S_BCHK: begin
          if (job_i.kind == KIND_INSERT) begin
            mt_we   = 1'b1;
            bk_we   = 1'b1;
            dst_d   = TAW'(cnt_q[IW-1:0] * SLOT);
            j_d     = '0;
            state_d = S_CPRD;
          end else if (!bk_rdata[BW-1]) begin
            res_d = STAT_MISS;
            res_pend_d = 1'b1;
          end else begin
            pos_d   = bk_rdata[IW-1:0];
            state_d = S_MRD;
          end
        end
        S_MRD: begin
          if (CW'(pos_q) >= cnt_q) begin
            res_d = STAT_MISS;
            res_pend_d = 1'b1;
          end else begin
            base_d  = TAW'(pos_q * SLOT);
            state_d = S_MCHK;
          end
        end
        S_MCHK: begin
          end_d  = m_end;
          next_d = m_next;
          vl_d   = m_vl;
          j_d    = '0;
          if (m_hash == job_i.hash && m_kl == kl_q) begin
            state_d = S_CRD;
          end else if (m_end) begin
            res_d = STAT_MISS;
            res_pend_d = 1'b1;
          end else begin
            pos_d   = m_next;
            state_d = S_MRD;
          end
        end
        S_CRD: begin
          state_d = S_CCMP;
        end
        S_CCMP: begin
          if (fold(tx_rdata) != fold(prdata_i)) begin
            if (end_q) begin
              res_d = STAT_MISS;
              res_pend_d = 1'b1;
            end else begin
              pos_d   = next_q;
              state_d = S_MRD;
            end
          end else if (j_q == LEN_W'(kl_q) - 1'b1) begin
            j_d = '0;
            if (vl_q == '0) begin
              res_d = STAT_FOUND;
              res_pend_d = 1'b1;
            end else begin
              state_d = S_VRD;
            end
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_CRD;
          end
        end
        S_VRD, S_VOUT: begin
          tx_raddr = base_q + TAW'(kl_q) + TAW'(j_q);
          if (state_q == S_VRD) begin
            state_d = S_VOUT;
          end else if (!out_full_i) begin
            out_push_o = 1'b1;
            out_o = '{status: STAT_FOUND, value_byte: tx_rdata, value_valid: 1'b1,
                      run_end: j_q == LEN_W'(vl_q) - 1'b1};
            if (j_q == LEN_W'(vl_q) - 1'b1) begin
              job_pop_o = 1'b1;
              state_d   = S_IDLE;
            end else begin
              j_d     = j_q + 1'b1;
              state_d = S_VRD;
            end
          end
        end
        S_CPRD: begin
          state_d = S_CPWR;
        end
        S_CPWR: begin
          if (!(job_i.cmode && j_q == job_i.kpos)) begin
            tx_we = 1'b1;
            dst_d = dst_q + 1'b1;
          end
          if (j_q == job_i.len - 1'b1) begin
            res_d      = STAT_DONE;
            inc_d      = 1'b1;
            res_pend_d = 1'b1;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = S_CPRD;
          end
        end
        default: begin
          state_d = S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      cnt_q      <= '0;
      sweep_q    <= '0;
      inc_q      <= 1'b0;
      res_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      sweep_q    <= sweep_d;
      inc_q      <= inc_d;
      res_pend_q <= res_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    pos_q  <= pos_d;
    next_q <= next_d;
    base_q <= base_d;
    dst_q  <= dst_d;
    j_q    <= j_d;
    kl_q   <= kl_d;
    vl_q   <= vl_d;
    end_q  <= end_d;
  end
endmodule

[src/caseless_string_map_lookup_core.sv]
// Top level of the caseless string map: front end, job queue, back end.
// Depends on csml_pkg, csml_front, csml_fifo, csml_ram, csml_back.
//
// Input items (kind, data_byte, last) are pushed while full is low. Bytes
// of an entry or lookup key are buffered; the byte with last set closes the
// item and queues a job. A clear item queues a job at once. Results are read
// as a queue: while empty is low the oldest result is on out_item_o and pop
// takes it. A lookup hit on an entry with value bytes gives one result per
// value byte, run_end on the final one; every other closed item gives
// exactly one result. A closed item's back-end work is the job decode, the
// bucket remainder (product, quotient and remainder registers) and the bucket
// read; then S_CPRD and S_CPWR per entry byte copied, S_CRD and S_CCMP per
// key byte compared, S_MRD and S_MCHK per chain entry visited, and S_VRD and
// S_VOUT per value byte emitted. A clear sweeps the bucket heads in S_CLR.
// Two closed items may wait in the job queue; the front then holds full high.
// After reset the back end sweeps all BUCKETS bucket heads, one per cycle,
// and full stays high for those cycles. When pop is held low the result
// queue fills, the back end waits, and full rises once the job queue fills.
module caseless_string_map_lookup_core
  import csml_pkg::*;
#(
  parameter int ENTRIES   = 256,
  parameter int BUCKETS   = 64,
  parameter int KEY_MAX   = 32,
  parameter int VALUE_MAX = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push,
  input  in_item_t  in_item_i,
  output logic      full,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  output out_item_t out_item_o,
  output logic      empty,
  input  logic      pop
);
  localparam int PEND = KEY_MAX + VALUE_MAX + 1;
  localparam int PAW  = $clog2(2 * PEND);

  logic     hold, job_full, job_push, job_empty, job_pop;
  job_t     job_in, job_head;
  logic     pwe;
  logic [PAW-1:0] pwaddr, praddr;
  logic [7:0]     pwdata, prdata;
  logic      out_full, out_push;
  out_item_t out_in;
  logic [$bits(job_t)-1:0]      job_vec;
  logic [$bits(out_item_t)-1:0] out_vec;

  csml_front #(.KEY_MAX(KEY_MAX), .VALUE_MAX(VALUE_MAX)) u_front (
    .clk_i, .rst_ni, .push_i(push), .item_i(in_item_i), .full_o(full),
    .cfg_we_i, .cfg_wdata_i, .hold_i(hold), .job_full_i(job_full),
    .job_push_o(job_push), .job_o(job_in),
    .pwe_o(pwe), .pwaddr_o(pwaddr), .pwdata_o(pwdata)
  );

  csml_fifo #(.WIDTH($bits(job_t)), .DEPTH(2)) u_job_q (
    .clk_i, .rst_ni, .push_i(job_push), .data_i(job_in), .full_o(job_full),
    .pop_i(job_pop), .empty_o(job_empty), .data_o(job_vec)
  );
  assign job_head = job_t'(job_vec);

  csml_ram #(.WIDTH(8), .DEPTH(2 * PEND)) u_pend (
    .clk_i, .we_i(pwe), .waddr_i(pwaddr), .wdata_i(pwdata),
    .raddr_i(praddr), .rdata_o(prdata)
  );

  csml_back #(
    .ENTRIES(ENTRIES), .BUCKETS(BUCKETS), .KEY_MAX(KEY_MAX), .VALUE_MAX(VALUE_MAX)
  ) u_back (
    .clk_i, .rst_ni, .job_i(job_head), .job_empty_i(job_empty), .job_pop_o(job_pop),
    .out_full_i(out_full), .out_push_o(out_push), .out_o(out_in), .init_o(hold),
    .praddr_o(praddr), .prdata_i(prdata)
  );

  csml_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(4)) u_out_q (
    .clk_i, .rst_ni, .push_i(out_push), .data_i(out_in), .full_o(out_full),
    .pop_i(pop), .empty_o(empty), .data_o(out_vec)
  );
  assign out_item_o = out_item_t'(out_vec);
endmodule

[sim/tb.sv]
// Self-checking testbench for caseless_string_map_lookup_core.
// Depends on csml_pkg and the core; drives byte items, predicts every result
// and checks it against the core's result queue.
`timescale 1ns / 100ps

module tb;
  import csml_pkg::*;

  localparam int ENTRIES   = 256;
  localparam int BUCKETS   = 64;
  localparam int KEY_MAX   = 32;
  localparam int VALUE_MAX = 32;
  localparam int SLOT      = KEY_MAX + VALUE_MAX;
  localparam int PEND      = SLOT + 1;
  localparam int N_ITEMS   = 320;

  class result_board;
    out_item_t waiting[$];
    int errors;
    int checked;

    function void note(out_item_t r);
      waiting.push_back(r);
    endfunction

    function void check(out_item_t got);
      out_item_t want;
      checked++;
      if (waiting.size() == 0) begin
        $error("unexpected result item status=%0d byte=%0h", got.status, got.value_byte);
        errors++;
        return;
      end
      want = waiting.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.value_byte !== want.value_byte) begin
        $error("value_byte: expected %0h, got %0h", want.value_byte, got.value_byte);
        errors++;
      end
      if (got.value_valid !== want.value_valid) begin
        $error("value_valid: expected %0b, got %0b", want.value_valid, got.value_valid);
        errors++;
      end
      if (got.run_end !== want.run_end) begin
        $error("run_end: expected %0b, got %0b", want.run_end, got.run_end);
        errors++;
      end
    endfunction
  endclass

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      push = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      cfg_we = 1'b0;
  logic      cfg_wdata = 1'b0;
  out_item_t out_item;
  logic      empty;
  logic      pop = 1'b0;

  bit calm = 1'b0;
  int sent = 0;
  int n_hits = 0, n_miss = 0, n_full = 0, n_long = 0;
  result_board board = new();

  always #5 clk_i = ~clk_i;

  caseless_string_map_lookup_core #(
    .ENTRIES(ENTRIES), .BUCKETS(BUCKETS), .KEY_MAX(KEY_MAX), .VALUE_MAX(VALUE_MAX)
  ) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .push(push), .in_item_i(in_item), .full(full),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .out_item_o(out_item), .empty(empty), .pop(pop)
  );

  // map shadow
  bit          split_mode = 1'b1;
  bit          bk_used[BUCKETS];
  int          bk_head[BUCKETS];
  logic [7:0]  ent_text[ENTRIES][SLOT];
  int          key_len[ENTRIES];
  int          val_len[ENTRIES];
  logic [31:0] ent_hash[ENTRIES];
  int          nxt[ENTRIES];
  bit          cend[ENTRIES];
  int          n_entries = 0;
  logic [7:0]  pend[PEND];
  int          pend_len = 0;
  bit          p_over = 0, p_colon = 0, p_act = 0;
  logic [1:0]  p_kind = KIND_INSERT;

  function automatic logic [7:0] fold_byte(logic [7:0] b);
    logic [7:0] c;
    c = b - 8'd65;
    if (c <= 8'd25) c = c + 8'd32;
    return c;
  endfunction

  function automatic out_item_t mk(logic [2:0] st, logic [7:0] b, bit v, bit e);
    out_item_t r;
    r.status = st;
    r.value_byte = b;
    r.value_valid = v;
    r.run_end = e;
    return r;
  endfunction

  function automatic void drop_pending();
    pend_len = 0;
    p_over = 0;
    p_colon = 0;
    p_act = 0;
    p_kind = KIND_INSERT;
  endfunction

  function automatic void answer(logic [2:0] st);
    board.note(mk(st, 8'd0, 1'b0, 1'b1));
    if (st == STAT_MISS) n_miss++;
    if (st == STAT_FULL) n_full++;
    if (st == STAT_LONG) n_long++;
  endfunction

  function automatic void predict(in_item_t it);
    logic [7:0]  buff[PEND];
    logic [31:0] h;
    int len, k, vl, pos, steps, bk;
    bit over, colon, same;
    if (it.kind == 2'd3) return;
    if (it.kind == KIND_CLEAR) begin
      foreach (bk_used[i]) bk_used[i] = 0;
      n_entries = 0;
      drop_pending();
      answer(STAT_DONE);
      return;
    end
    if (p_act && p_kind != it.kind) drop_pending();
    p_act = 1;
    p_kind = it.kind;
    if (it.data_byte == COLON) p_colon = 1;
    if (pend_len < PEND) begin
      pend[pend_len] = it.data_byte;
      pend_len++;
    end else p_over = 1;
    if (!it.last) return;
    len = pend_len;
    over = p_over;
    colon = p_colon;
    buff = pend;
    drop_pending();
    if (it.kind == KIND_INSERT) begin
      if (split_mode && !colon) begin answer(STAT_DONE); return; end
      if (over) begin answer(STAT_LONG); return; end
      if (split_mode) begin
        k = 0;
        while (k < len && buff[k] != COLON) k++;
        vl = (k < len) ? len - k - 1 : 0;
      end else begin
        k = len;
        vl = 0;
      end
      if (k > KEY_MAX || vl > VALUE_MAX) begin answer(STAT_LONG); return; end
      if (n_entries >= ENTRIES) begin answer(STAT_FULL); return; end
      h = HASH_SEED;
      for (int i = 0; i < k; i++) begin
        ent_text[n_entries][i] = buff[i];
        h = h * 33 ^ {24'd0, fold_byte(buff[i])};
      end
      for (int i = 0; i < vl; i++) ent_text[n_entries][k + i] = buff[k + 1 + i];
      key_len[n_entries] = k;
      val_len[n_entries] = vl;
      ent_hash[n_entries] = h;
      bk = h % BUCKETS;
      cend[n_entries] = !bk_used[bk];
      nxt[n_entries] = bk_head[bk];
      bk_head[bk] = n_entries;
      bk_used[bk] = 1;
      n_entries++;
      answer(STAT_DONE);
      return;
    end
    if (over || len > KEY_MAX) begin answer(STAT_LONG); return; end
    h = HASH_SEED;
    for (int i = 0; i < len; i++) h = h * 33 ^ {24'd0, fold_byte(buff[i])};
    bk = h % BUCKETS;
    if (bk_used[bk]) begin
      pos = bk_head[bk];
      for (steps = 0; steps < ENTRIES && pos < n_entries; steps++) begin
        if (ent_hash[pos] == h && key_len[pos] == len) begin
          same = 1;
          for (int i = 0; i < len; i++)
            if (fold_byte(ent_text[pos][i]) != fold_byte(buff[i])) same = 0;
          if (same) begin
            n_hits++;
            if (val_len[pos] == 0) board.note(mk(STAT_FOUND, 8'd0, 1'b0, 1'b1));
            for (int i = 0; i < val_len[pos]; i++)
              board.note(mk(STAT_FOUND, ent_text[pos][len + i], 1'b1, i + 1 == val_len[pos]));
            return;
          end
        end
        if (cend[pos]) break;
        pos = nxt[pos];
      end
    end
    answer(STAT_MISS);
  endfunction

  task automatic send(logic [1:0] kind, logic [7:0] b, bit last);
    in_item_t it;
    it.kind = kind;
    it.data_byte = b;
    it.last = last;
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    push <= 1'b1;
    in_item <= it;
    do @(posedge clk_i); while (full);
    predict(it);
    if (kind != 2'd3) sent++;
  endtask

  task automatic send_text(logic [1:0] kind, logic [7:0] txt[$]);
    foreach (txt[i]) send(kind, txt[i], i == txt.size() - 1);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (board.waiting.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_split(bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    split_mode = v;
    cfg_we <= 1'b0;
  endtask

  function automatic logic [7:0] rand_keybyte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == COLON);
    return b;
  endfunction

  function automatic logic [7:0] flip_case(logic [7:0] b);
    if ($urandom_range(0, 1) && ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z")))
      return b ^ 8'h20;
    return b;
  endfunction

  logic [7:0] keys[8][$];

  task automatic random_part(int count, bit tail);
    logic [7:0] t[$];
    int sel, n, goal;
    goal = sent + count;
    while (sent < goal) begin
      if (tail && sent > goal - count / 4) calm = 1'b1;
      t = {};
      sel = $urandom_range(0, 99);
      n = $urandom_range(0, 7);
      if (sel < 35) begin
        for (int i = 0; i < keys[n].size(); i++) t.push_back(flip_case(keys[n][i]));
        if (split_mode) begin
          t.push_back(COLON);
          repeat ($urandom_range(0, 5)) t.push_back(8'($urandom_range(0, 255)));
        end
        send_text(KIND_INSERT, t);
      end else if (sel < 75) begin
        for (int i = 0; i < keys[n].size(); i++) t.push_back(flip_case(keys[n][i]));
        if ($urandom_range(0, 5) == 0) t.push_back(rand_keybyte());
        send_text(KIND_LOOKUP, t);
      end else if (sel < 79) begin
        send(KIND_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (sel < 82) begin
        send(2'd3, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      end else if (sel < 86) begin
        repeat ($urandom_range(1, 3)) send(KIND_INSERT, rand_keybyte(), 1'b0);
        send(KIND_LOOKUP, rand_keybyte(), 1'($urandom_range(0, 1)));
      end else if (sel < 90) begin
        repeat ($urandom_range(33, 38)) t.push_back(rand_keybyte());
        if ($urandom_range(0, 1)) begin
          send_text(KIND_LOOKUP, t);
        end else begin
          t.push_back(COLON);
          send_text(KIND_INSERT, t);
        end
      end else if (sel < 93) begin
        t.push_back(rand_keybyte());
        t.push_back(COLON);
        repeat ($urandom_range(31, 36)) t.push_back(8'($urandom_range(0, 255)));
        send_text(KIND_INSERT, t);
      end else if (sel < 95) begin
        repeat ($urandom_range(64, 70)) t.push_back(8'($urandom_range(0, 255)));
        send_text(KIND_INSERT, t);
      end else begin
        repeat ($urandom_range(1, 6)) t.push_back(8'($urandom_range(0, 255)));
        send_text(2'($urandom_range(0, 1)), t);
      end
    end
  endtask

  initial begin
    int stall;
    stall = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty) board.check(out_item);
      if (stall > 0) begin
        stall--;
        pop <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 10) - 1;
        pop <= 1'b0;
      end else pop <= 1'b1;
    end
  end

  initial begin
    foreach (bk_used[i]) begin
      bk_used[i] = 0;
      bk_head[i] = 0;
    end
    foreach (keys[i]) repeat ($urandom_range(1, 6)) keys[i].push_back(rand_keybyte());
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_text(KIND_INSERT, '{"K", "e", "Y", ":", 8'h00, 8'hFF});
    send_text(KIND_LOOKUP, '{"k", "E", "y"});
    send_text(KIND_LOOKUP, '{"k", "q"});
    send_text(KIND_INSERT, '{8'hFF, ":"});
    send_text(KIND_LOOKUP, '{8'hFF});
    send_text(KIND_INSERT, '{"n", "o"});
    send(2'd3, 8'hFF, 1'b1);
    send(KIND_INSERT, "z", 1'b0);
    send(KIND_LOOKUP, "K", 1'b0);
    send_text(KIND_LOOKUP, '{"e", "y"});
    send(KIND_CLEAR, 8'h00, 1'b0);
    send_text(KIND_LOOKUP, '{"k", "e", "y"});
    drain();

    // table full, then back to normal operation
    repeat (ENTRIES + 2) send(KIND_INSERT, COLON, 1'b1);
    send_text(KIND_LOOKUP, '{"x"});
    send(KIND_CLEAR, 8'h55, 1'b1);
    random_part(12, 1'b0);
    drain();
    set_split(1'b0);
    random_part(12, 1'b0);
    drain();
    set_split(1'b1);
    random_part((N_ITEMS > sent + 20) ? N_ITEMS - sent : 20, 1'b1);
    drain();

    $display("%0d items sent, %0d results checked: %0d hits, %0d misses, %0d full, %0d long",
             sent, board.checked, n_hits, n_miss, n_full, n_long);
    if (board.errors == 0 && board.waiting.size() == 0) begin
      $display("** caseless_string_map_lookup_core: PASSED **");
    end else begin
      $display("** caseless_string_map_lookup_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("** caseless_string_map_lookup_core: FAILED **");
    $finish;
  end

endmodule

[sim.f]
src/csml_pkg.sv
src/csml_ram.sv
src/csml_fifo.sv
src/csml_mod.sv
src/csml_front.sv
src/csml_back.sv
src/caseless_string_map_lookup_core.sv
sim/tb.sv
